FILE: design/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
// Holds the register index codes, the field widths and pattern byte extraction.
// No dependencies.
package mbps_pkg;

	localparam int DATA_BITS          = 8;
	localparam int ADDR_FIELD_BITS    = 32;
	localparam int COUNT_BITS         = 32;
	localparam int CFG_DATA_BITS      = 64;
	localparam int CFG_INDEX_BITS     = 3;
	localparam int LENGTH_REG_BITS    = 5;
	localparam int REG_PATTERN_BYTES  = 24;
	localparam int REG_PATTERN_BITS   = REG_PATTERN_BYTES * DATA_BITS;

	typedef logic [CFG_INDEX_BITS-1:0]   cfg_index_t;
	typedef logic [REG_PATTERN_BITS-1:0] pattern_flat_t;
	typedef logic [DATA_BITS-1:0]        byte_t;

	localparam cfg_index_t REG_VALUE_LOW   = 3'd0;
	localparam cfg_index_t REG_VALUE_MID   = 3'd1;
	localparam cfg_index_t REG_VALUE_HIGH  = 3'd2;
	localparam cfg_index_t REG_MASK_LOW    = 3'd3;
	localparam cfg_index_t REG_MASK_MID    = 3'd4;
	localparam cfg_index_t REG_MASK_HIGH   = 3'd5;
	localparam cfg_index_t REG_LENGTH      = 3'd6;
	localparam cfg_index_t REG_SINGLE_MODE = 3'd7;

	// Bytes past the register file act as a full wildcard with a zero value.
	function automatic byte_t pattern_byte(input pattern_flat_t flat, input int idx);
		byte_t b;
		b = '0;
		if (idx >= 0 && idx < REG_PATTERN_BYTES) begin
			b = flat[idx*DATA_BITS +: DATA_BITS];
		end
		return b;
	endfunction

endpackage

FILE: design/masked_byte_pattern_scanner.sv
// Two register stages: the input register, then the result register.
// Throughput: one word per cycle unless the result register stalls; the input
// register feeds one pass of window shift, parallel masked compare and count update
// straight into the result register.
// Reset: arst_n clears the window fill, the found flag, the match count, the
// pipeline valid bits and the registers (pattern length resets to 1).
// Depends on mbps_pkg.
module masked_byte_pattern_scanner #(
	parameter int MAX_PATTERN_BYTES = 24,
	parameter int ADDRESS_BITS      = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mbps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [mbps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [mbps_pkg::DATA_BITS-1:0]        data_byte,
	input  logic [mbps_pkg::ADDR_FIELD_BITS-1:0]  byte_address,
	input  logic                                  region_first,
	input  logic                                  scan_first,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mbps_pkg::ADDR_FIELD_BITS-1:0]  match_address,
	output logic [mbps_pkg::COUNT_BITS-1:0]       match_count
);

	localparam int LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int AW     = mbps_pkg::ADDR_FIELD_BITS;
	localparam logic [AW-1:0] ADDR_MASK =
		(ADDRESS_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDRESS_BITS) - 64'd1);

	// Configuration registers.
	logic [mbps_pkg::CFG_DATA_BITS-1:0]   val_low_q, val_mid_q, val_high_q;
	logic [mbps_pkg::CFG_DATA_BITS-1:0]   mask_low_q, mask_mid_q, mask_high_q;
	logic [mbps_pkg::LENGTH_REG_BITS-1:0] pattern_length_q;
	logic                                 single_mode_q;

	// Input stage.
	logic                                  valid_s1;
	logic [mbps_pkg::DATA_BITS-1:0]        data_byte_s1;
	logic [AW-1:0]                         byte_address_s1;
	logic                                  region_first_s1;
	logic                                  scan_first_s1;

	// Scan state.
	logic [mbps_pkg::DATA_BITS-1:0] win_q [MAX_PATTERN_BYTES];
	logic [mbps_pkg::DATA_BITS-1:0] win_n [MAX_PATTERN_BYTES];
	logic [LEN_W-1:0]               fill_q;
	logic [LEN_W-1:0]               fill_n;
	logic                           found_q;
	logic [mbps_pkg::COUNT_BITS-1:0] cnt_q;

	// Result register.
	logic                            out_valid_q;
	logic [AW-1:0]                   match_address_q;
	logic [mbps_pkg::COUNT_BITS-1:0] match_count_q;

	logic                            advance;
	logic                            process;
	logic [LEN_W-1:0]                len_use;
	logic                            hit;
	logic                            emit;
	logic                            found_base;
	logic [mbps_pkg::COUNT_BITS-1:0] cnt_base;
	logic [mbps_pkg::COUNT_BITS-1:0] cnt_next;
	logic [AW-1:0]                   addr_next;
	mbps_pkg::pattern_flat_t         val_flat;
	mbps_pkg::pattern_flat_t         mask_flat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_low_q        <= '0;
			val_mid_q        <= '0;
			val_high_q       <= '0;
			mask_low_q       <= '0;
			mask_mid_q       <= '0;
			mask_high_q      <= '0;
			pattern_length_q <= mbps_pkg::LENGTH_REG_BITS'(1);
			single_mode_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mbps_pkg::REG_VALUE_LOW:   val_low_q   <= cfg_data;
				mbps_pkg::REG_VALUE_MID:   val_mid_q   <= cfg_data;
				mbps_pkg::REG_VALUE_HIGH:  val_high_q  <= cfg_data;
				mbps_pkg::REG_MASK_LOW:    mask_low_q  <= cfg_data;
				mbps_pkg::REG_MASK_MID:    mask_mid_q  <= cfg_data;
				mbps_pkg::REG_MASK_HIGH:   mask_high_q <= cfg_data;
				mbps_pkg::REG_LENGTH:
					pattern_length_q <= cfg_data[mbps_pkg::LENGTH_REG_BITS-1:0];
				mbps_pkg::REG_SINGLE_MODE: single_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign val_flat  = {val_high_q, val_mid_q, val_low_q};
	assign mask_flat = {mask_high_q, mask_mid_q, mask_low_q};

	// The stage moves whenever the result register is empty or being drained.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign process  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1    <= data_byte;
			byte_address_s1 <= byte_address;
			region_first_s1 <= region_first;
			scan_first_s1   <= scan_first;
		end
	end

	// A zero length acts as one; a length beyond the window is clamped.
	always_comb begin
		if (pattern_length_q == '0) begin
			len_use = LEN_W'(1);
		end else if (int'(pattern_length_q) > MAX_PATTERN_BYTES) begin
			len_use = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len_use = LEN_W'(pattern_length_q);
		end
	end

	// Newest byte enters at the top of the window.
	always_comb begin
		for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) begin
			win_n[k] = win_q[k+1];
		end
		win_n[MAX_PATTERN_BYTES-1] = data_byte_s1;
	end

	always_comb begin
		fill_n = (scan_first_s1 || region_first_s1) ? '0 : fill_q;
		if (int'(fill_n) < MAX_PATTERN_BYTES) begin
			fill_n = fill_n + LEN_W'(1);
		end
	end

	// Pattern byte i lines up with the window byte that lies len-1-i places
	// below the newest one.
	always_comb begin
		logic [mbps_pkg::DATA_BITS-1:0] wbyte;
		wbyte = '0;
		hit = (fill_n >= len_use);
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			if (i < int'(len_use)) begin
				wbyte = win_n[IDX_W'(MAX_PATTERN_BYTES - int'(len_use) + i)];
				if ((wbyte & mbps_pkg::pattern_byte(mask_flat, i))
				    != mbps_pkg::pattern_byte(val_flat, i)) begin
					hit = 1'b0;
				end
			end
		end
	end

	assign found_base = scan_first_s1 ? 1'b0 : found_q;
	assign cnt_base   = scan_first_s1 ? '0 : cnt_q;
	assign emit       = process && hit && !(single_mode_q && found_base);
	assign cnt_next   = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
	assign addr_next  = (byte_address_s1 - AW'(len_use) + AW'(1)) & ADDR_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			found_q <= 1'b0;
			cnt_q   <= '0;
		end else if (process) begin
			fill_q  <= fill_n;
			found_q <= emit ? 1'b1 : found_base;
			cnt_q   <= emit ? cnt_next : cnt_base;
		end
	end

	// The window contents are only read below the fill level, so no reset.
	always_ff @(posedge clk) begin
		if (process) begin
			for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
				win_q[k] <= win_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			match_address_q <= addr_next;
			match_count_q   <= cnt_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;
	assign match_count   = match_count_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_PATTERN_BYTES)
		else $error("window fill exceeds the window depth");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> match_count_q != '0)
		else $error("reported word carries a zero match count");

	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> found_q && out_valid_q && match_count_q == cnt_q)
		else $error("result register and scan state disagree after a match");

	a_single_once: assert property (@(posedge clk) disable iff (!arst_n)
		emit && single_mode_q && !scan_first_s1 |-> !found_q)
		else $error("second match reported in single mode");

endmodule

FILE: test/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 100ps
// Testbench for masked_byte_pattern_scanner: a directed table of bytes and register
// writes, then random pattern phases, every match word checked against a local predictor or a typed row.
// Depends on mbps_pkg and the scanner RTL only.
module tb_masked_byte_pattern_scanner;

	localparam int WIN_BYTES = mbps_pkg::REG_PATTERN_BYTES;
	localparam int DB = mbps_pkg::DATA_BITS;
	localparam int AB = mbps_pkg::ADDR_FIELD_BITS;
	localparam int CB = mbps_pkg::CFG_DATA_BITS;
	localparam int LB = mbps_pkg::LENGTH_REG_BITS;
	localparam int RANDOM_BYTES = 450;

	typedef struct packed {
		logic [AB-1:0]                   addr;
		logic [mbps_pkg::COUNT_BITS-1:0] count;
	} match_t;

	typedef enum logic [1:0] {ROW_BYTE, ROW_REG} row_kind_t;
	typedef enum logic [1:0] {FROM_PREDICTOR, TYPED_NONE, TYPED_HIT} row_check_t;

	typedef struct {
		row_kind_t            kind;
		mbps_pkg::cfg_index_t idx;
		logic [CB-1:0]        word;
		mbps_pkg::byte_t      data;
		logic [AB-1:0]        addr;
		logic                 rf;
		logic                 sf;
		row_check_t           chk;
		match_t               typed;
	} row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	mbps_pkg::cfg_index_t            cfg_index = mbps_pkg::REG_VALUE_LOW;
	logic [CB-1:0]                   cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	mbps_pkg::byte_t                 data_byte = '0;
	logic [AB-1:0]                   byte_address = '0;
	logic                            region_first = 1'b0;
	logic                            scan_first = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [AB-1:0]                   match_address;
	logic [mbps_pkg::COUNT_BITS-1:0] match_count;

	masked_byte_pattern_scanner u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.byte_address (byte_address),
		.region_first (region_first),
		.scan_first   (scan_first),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.match_address(match_address),
		.match_count  (match_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor copy of the pattern registers and the scan state.
	mbps_pkg::pattern_flat_t         pat_value;
	mbps_pkg::pattern_flat_t         pat_mask;
	logic [LB-1:0]                   len_reg;
	logic                            single_reg;
	mbps_pkg::byte_t                 win [WIN_BYTES];
	int unsigned                     win_fill;
	logic                            scan_found;
	logic [mbps_pkg::COUNT_BITS-1:0] scan_count;

	match_t      pending_matches[$];
	match_t      want_match;
	row_t        rows[$];
	int          errors = 0;
	int unsigned burst_left = 0;
	int unsigned scan_bytes_sent = 0;
	logic [AB-1:0] next_addr = '0;
	logic        pend_rf = 1'b0;
	logic        pend_sf = 1'b0;
	int unsigned ready_mode = 0;
	int unsigned mode_left = 0;

	function automatic int unsigned active_length();
		if (len_reg == 0) return 1;
		if (len_reg > WIN_BYTES) return WIN_BYTES;
		return len_reg;
	endfunction

	task automatic scan_byte(input mbps_pkg::byte_t d, input logic [AB-1:0] a,
		input logic rf, input logic sf, output logic hit, output match_t m);
		int unsigned n;
		hit = 1'b0;
		m = '0;
		if (sf) begin
			scan_found = 1'b0;
			scan_count = '0;
		end
		if (sf || rf) win_fill = 0;
		for (int i = 0; i < WIN_BYTES - 1; i++) win[i] = win[i + 1];
		win[WIN_BYTES - 1] = d;
		if (win_fill < WIN_BYTES) win_fill++;
		n = active_length();
		if (win_fill >= n) begin
			hit = 1'b1;
			for (int i = 0; i < n; i++) begin
				if ((win[WIN_BYTES - n + i] & pat_mask[i*DB +: DB])
						!= pat_value[i*DB +: DB]) hit = 1'b0;
			end
			if (single_reg && scan_found) hit = 1'b0;
		end
		if (hit) begin
			scan_found = 1'b1;
			if (scan_count != '1) scan_count++;
			m.addr = a - AB'(n - 1);
			m.count = scan_count;
		end
	endtask

	task automatic expect_match(input match_t m);
		pending_matches.insert(pending_matches.size(), m);
	endtask

	task automatic write_reg(input mbps_pkg::cfg_index_t idx, input logic [CB-1:0] w);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		unique case (idx)
			mbps_pkg::REG_VALUE_LOW:   pat_value[0 +: CB] = w;
			mbps_pkg::REG_VALUE_MID:   pat_value[CB +: CB] = w;
			mbps_pkg::REG_VALUE_HIGH:  pat_value[2*CB +: CB] = w;
			mbps_pkg::REG_MASK_LOW:    pat_mask[0 +: CB] = w;
			mbps_pkg::REG_MASK_MID:    pat_mask[CB +: CB] = w;
			mbps_pkg::REG_MASK_HIGH:   pat_mask[2*CB +: CB] = w;
			mbps_pkg::REG_LENGTH:      len_reg = w[LB-1:0];
			mbps_pkg::REG_SINGLE_MODE: single_reg = w[0];
			default: ;
		endcase
	endtask

	// The register channel is left valid between back-to-back writes and goes
	// quiet here, once bytes start to flow again.
	task automatic send_byte(input mbps_pkg::byte_t d, input logic [AB-1:0] a,
		input logic rf, input logic sf, input row_check_t chk, input match_t typed);
		int unsigned gap;
		logic hit;
		match_t m;
		cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= d;
		byte_address <= a;
		region_first <= rf;
		scan_first <= sf;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		scan_byte(d, a, rf, sf, hit, m);
		if (chk == TYPED_HIT) expect_match(typed);
		else if (chk == FROM_PREDICTOR && hit) expect_match(m);
	endtask

	task automatic drain_matches();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_matches.size() != 0);
	endtask

	// A byte that ends in no match may still be in the pipe when the queue is
	// empty, so give the two register stages some slack before touching registers.
	task automatic settle_for_regs();
		drain_matches();
		repeat (4) @(posedge clk);
	endtask

	task automatic add_reg(input mbps_pkg::cfg_index_t idx, input logic [CB-1:0] w);
		row_t r;
		r.kind = ROW_REG;
		r.idx = idx;
		r.word = w;
		r.data = '0;
		r.addr = '0;
		r.rf = 1'b0;
		r.sf = 1'b0;
		r.chk = FROM_PREDICTOR;
		r.typed = '0;
		rows.insert(rows.size(), r);
	endtask

	task automatic add_byte(input mbps_pkg::byte_t d, input logic [AB-1:0] a,
		input logic rf, input logic sf, input row_check_t chk,
		input logic [AB-1:0] t_addr, input logic [mbps_pkg::COUNT_BITS-1:0] t_count);
		row_t r;
		r.kind = ROW_BYTE;
		r.idx = mbps_pkg::REG_VALUE_LOW;
		r.word = '0;
		r.data = d;
		r.addr = a;
		r.rf = rf;
		r.sf = sf;
		r.chk = chk;
		r.typed.addr = t_addr;
		r.typed.count = t_count;
		rows.insert(rows.size(), r);
	endtask

	task automatic load_random_pattern(input int unsigned len_code, input logic one_hit,
		input logic all_ones);
		mbps_pkg::pattern_flat_t v;
		mbps_pkg::pattern_flat_t mk;
		mbps_pkg::byte_t mb;
		logic [CB-1:0] junk;
		for (int i = 0; i < WIN_BYTES; i++) begin
			case ($urandom_range(0, 9)) inside
				[0:2]:   mb = 8'h00;
				[3:4]:   mb = 8'hF0;
				9:       mb = mbps_pkg::byte_t'($urandom);
				default: mb = 8'hFF;
			endcase
			mk[i*DB +: DB] = mb;
			v[i*DB +: DB] = mbps_pkg::byte_t'($urandom) & mb;
			// A value bit where the mask is clear makes the pattern unmatchable if that byte is in use.
			if (mb != 8'hFF && $urandom_range(0, 59) == 0)
				v[i*DB +: DB] = v[i*DB +: DB] | (~mb & mbps_pkg::byte_t'($urandom));
		end
		if (all_ones) begin
			v = '1;
			mk = '1;
		end
		junk = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : '0;
		write_reg(mbps_pkg::REG_VALUE_LOW, v[0 +: CB]);
		write_reg(mbps_pkg::REG_VALUE_MID, v[CB +: CB]);
		write_reg(mbps_pkg::REG_VALUE_HIGH, v[2*CB +: CB]);
		write_reg(mbps_pkg::REG_MASK_LOW, mk[0 +: CB]);
		write_reg(mbps_pkg::REG_MASK_MID, mk[CB +: CB]);
		write_reg(mbps_pkg::REG_MASK_HIGH, mk[2*CB +: CB]);
		write_reg(mbps_pkg::REG_LENGTH, {junk[CB-1:LB], LB'(len_code)});
		write_reg(mbps_pkg::REG_SINGLE_MODE, {junk[CB-1:1], one_hit});
	endtask

	task automatic jump_address();
		case ($urandom_range(0, 3))
			0:       next_addr = 32'hFFFF_FFFF - $urandom_range(0, 30);
			1:       next_addr = $urandom_range(0, 30);
			default: next_addr = $urandom;
		endcase
	endtask

	task automatic feed(input mbps_pkg::byte_t b, input int unsigned pause_at);
		send_byte(b, next_addr, pend_rf, pend_sf, FROM_PREDICTOR, '0);
		pend_rf = 1'b0;
		pend_sf = 1'b0;
		next_addr++;
		scan_bytes_sent++;
		if (scan_bytes_sent == pause_at) drain_matches();
	endtask

	// Mostly planted matches with random don't-care bits, mixed with noise
	// and with region and scan starts that break sequences apart.
	task automatic run_phase(input int unsigned budget);
		int unsigned stop_at;
		int unsigned pause_at;
		int unsigned k;
		int unsigned n;
		mbps_pkg::byte_t b;
		stop_at = scan_bytes_sent + budget;
		pause_at = ($urandom_range(0, 2) == 0) ? scan_bytes_sent + $urandom_range(1, budget) : 0;
		while (scan_bytes_sent < stop_at) begin
			k = $urandom_range(0, 99);
			if (k < 6) begin
				pend_sf = 1'b1;
				pend_rf = 1'($urandom_range(0, 1));
				jump_address();
			end else if (k < 16) begin
				pend_rf = 1'b1;
				jump_address();
			end else if (k < 60) begin
				n = active_length();
				for (int i = 0; i < n; i++) begin
					b = pat_value[i*DB +: DB]
						| (mbps_pkg::byte_t'($urandom) & ~pat_mask[i*DB +: DB]);
					feed(b, pause_at);
				end
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) feed(mbps_pkg::byte_t'($urandom), pause_at);
			end
		end
	endtask

	always @(posedge clk) begin
		if (mode_left == 0) begin
			mode_left = $urandom_range(20, 80);
			ready_mode = $urandom_range(0, 3);
		end
		mode_left--;
		case (ready_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			2:       out_ready <= (mode_left % 4 == 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
		if (arst_n && out_valid && out_ready) begin
			if (pending_matches.size() == 0) begin
				$display("%0t: unexpected match word: expected none, actual address %h count %0d",
					$time, match_address, match_count);
				errors++;
			end else begin
				want_match = pending_matches.pop_front();
				if (match_address !== want_match.addr) begin
					$display("%0t: match_address: expected %h, actual %h",
						$time, want_match.addr, match_address);
					errors++;
				end
				if (match_count !== want_match.count) begin
					$display("%0t: match_count: expected %0d, actual %0d",
						$time, want_match.count, match_count);
					errors++;
				end
			end
		end
	end

	initial begin
		logic prev_reg;
		int unsigned len_code;
		logic one_hit;
		logic all_ones;
		int unsigned w;
		pat_value = '0;
		pat_mask = '0;
		len_reg = LB'(1);
		single_reg = 1'b0;
		foreach (win[i]) win[i] = '0;
		win_fill = 0;
		scan_found = 1'b0;
		scan_count = '0;

		// Reset values: length one with an all-wildcard byte, so every byte matches.
		add_byte(8'h00, 32'h0000_0000, 1'b0, 1'b1, TYPED_HIT, 32'h0000_0000, 32'd1);
		add_byte(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, TYPED_HIT, 32'hFFFF_FFFF, 32'd2);
		add_byte(8'h5A, 32'h0000_1234, 1'b1, 1'b0, TYPED_HIT, 32'h0000_1234, 32'd3);
		// Single mode keeps quiet until a new scan, even across a region start.
		add_reg(mbps_pkg::REG_SINGLE_MODE, 64'h1);
		add_byte(8'h11, 32'h0000_0100, 1'b0, 1'b1, TYPED_HIT, 32'h0000_0100, 32'd1);
		add_byte(8'h22, 32'h0000_0101, 1'b0, 1'b0, TYPED_NONE, '0, '0);
		add_byte(8'h33, 32'h0000_0102, 1'b1, 1'b0, TYPED_NONE, '0, '0);
		add_byte(8'h44, 32'h0000_0000, 1'b0, 1'b1, FROM_PREDICTOR, '0, '0);
		// A zero length acts as one.
		add_reg(mbps_pkg::REG_SINGLE_MODE, 64'h0);
		add_reg(mbps_pkg::REG_LENGTH, 64'h0);
		add_reg(mbps_pkg::REG_MASK_LOW, 64'hFF);
		add_reg(mbps_pkg::REG_VALUE_LOW, 64'hA5);
		add_byte(8'hA5, 32'h0000_0007, 1'b0, 1'b1, FROM_PREDICTOR, '0, '0);
		add_byte(8'hA4, 32'h0000_0008, 1'b0, 1'b0, FROM_PREDICTOR, '0, '0);
		add_byte(8'hA5, 32'h0000_0009, 1'b0, 1'b0, FROM_PREDICTOR, '0, '0);
		// Three bytes: full, high nibble, wildcard. The first hit wraps the address.
		add_reg(mbps_pkg::REG_LENGTH, 64'd3);
		add_reg(mbps_pkg::REG_MASK_LOW, 64'h00F0FF);
		add_reg(mbps_pkg::REG_VALUE_LOW, 64'h003012);
		add_byte(8'h12, 32'hFFFF_FFFF, 1'b0, 1'b1, FROM_PREDICTOR, '0, '0);
		add_byte(8'h3C, 32'h0000_0000, 1'b0, 1'b0, FROM_PREDICTOR, '0, '0);
		add_byte(8'h99, 32'h0000_0001, 1'b0, 1'b0, TYPED_HIT, 32'hFFFF_FFFF, 32'd1);
		add_byte(8'h12, 32'h0000_0010, 1'b0, 1'b0, FROM_PREDICTOR, '0, '0);
		add_byte(8'h30, 32'h0000_0011, 1'b0, 1'b0, FROM_PREDICTOR, '0, '0);
		// This would complete a match, but the region start cuts the window.
		add_byte(8'h00, 32'h0000_0012, 1'b1, 1'b0, FROM_PREDICTOR, '0, '0);
		add_byte(8'h12, 32'h0000_0013, 1'b0, 1'b0, FROM_PREDICTOR, '0, '0);
		add_byte(8'h3F, 32'h0000_0014, 1'b0, 1'b0, FROM_PREDICTOR, '0, '0);
		add_byte(8'hFF, 32'h0000_0015, 1'b0, 1'b0, FROM_PREDICTOR, '0, '0);
		// A value bit under a clear mask bit can never match.
		add_reg(mbps_pkg::REG_VALUE_LOW, 64'h003112);
		add_byte(8'h12, 32'h0000_0020, 1'b0, 1'b1, FROM_PREDICTOR, '0, '0);
		add_byte(8'h31, 32'h0000_0021, 1'b0, 1'b0, FROM_PREDICTOR, '0, '0);
		add_byte(8'h00, 32'h0000_0022, 1'b0, 1'b0, TYPED_NONE, '0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		prev_reg = 1'b1;
		foreach (rows[r]) begin
			if (rows[r].kind == ROW_REG) begin
				if (!prev_reg) settle_for_regs();
				write_reg(rows[r].idx, rows[r].word);
				prev_reg = 1'b1;
			end else begin
				send_byte(rows[r].data, rows[r].addr, rows[r].rf, rows[r].sf,
					rows[r].chk, rows[r].typed);
				prev_reg = 1'b0;
			end
		end

		scan_bytes_sent = 0;
		for (int ph = 0; scan_bytes_sent < RANDOM_BYTES; ph++) begin
			settle_for_regs();
			one_hit = ($urandom_range(0, 2) == 0);
			all_ones = 1'b0;
			case (ph)
				0: len_code = 31;
				1: begin
					len_code = 24;
					one_hit = 1'b1;
				end
				2: len_code = 0;
				3: begin
					len_code = 4;
					all_ones = 1'b1;
				end
				default: begin
					case ($urandom_range(0, 9)) inside
						[6:7]:   len_code = $urandom_range(9, 24);
						8:       len_code = 0;
						9:       len_code = $urandom_range(25, 31);
						default: len_code = $urandom_range(1, 8);
					endcase
				end
			endcase
			load_random_pattern(len_code, one_hit, all_ones);
			pend_sf = 1'b1;
			jump_address();
			run_phase($urandom_range(25, 45));
		end

		in_valid <= 1'b0;
		for (w = 0; w < 5000 && pending_matches.size() != 0; w++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_matches.size() != 0) begin
			$display("%0t: %0d match words missing: expected address %h, actual none",
				$time, pending_matches.size(), pending_matches[0].addr);
			errors++;
		end
		if (errors == 0) begin
			$display("masked_byte_pattern_scanner: match");
		end else begin
			$display("masked_byte_pattern_scanner: mismatch");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("masked_byte_pattern_scanner: mismatch");
		$finish;
	end

endmodule
